// ----- sv/kdre_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key debouncer package
// Shared types and constants for the key debouncer with release events.
// ----------------------------------------------------------------------------
package kdre_pkg;

   localparam int unsigned LevelBits = 8;
   localparam int unsigned KeyBits   = 4;

   typedef logic [LevelBits-1:0] levels_type;
   typedef logic [KeyBits-1:0]   key_type;
   typedef logic [7:0]           count_type;

   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_READ = 2'd1,
      KIND_INIT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_PRESCALE  = 2'd0,
      CSR_DEBOUNCE  = 2'd1,
      CSR_KEY_COUNT = 2'd2
   } csr_index_type;

   localparam count_type ResetPrescale = 8'd20;
   localparam count_type ResetDebounce = 8'd3;
   localparam key_type   ResetKeyCount = 4'd0;

   typedef struct packed {
      key_type event_value;
      key_type latest_key;
      key_type stable_key;
      logic    event_pending;
   } result_type;

endpackage : kdre_pkg
`default_nettype wire

// ----- sv/kdre_encode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key priority encoder
// Returns the number (position + 1) of the lowest enabled pressed key, or 0.
// ----------------------------------------------------------------------------
module kdre_encode (
   input  kdre_pkg::levels_type levels,
   input  kdre_pkg::key_type    enabled_keys,
   output kdre_pkg::key_type    key_number
);
   import kdre_pkg::*;

   always_comb begin
      key_number = '0;
      // Scan from the top so that the lowest pressed position wins.
      for (int i = LevelBits - 1; i >= 0; i--) begin
         if ((KeyBits'(i) < enabled_keys) && !levels[i]) begin
            key_number = KeyBits'(i + 1);
         end
      end
   end

endmodule : kdre_encode
`default_nettype wire

// ----- sv/key_debounce_release_event.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-key debouncer with release events
// Samples active-low key levels, debounces them and latches key releases.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the req_ channel (req_kind, req_key_levels): a tick carries a
// key sample, a read collects the pending release event, an init loads the
// debounce state from the sample. Every item yields exactly one result on the
// rsp_ channel with the event value and the status after the item.
// A transfer occurs on a rising edge with valid high and stall low.
// The first stage registers the item; the second updates the key state and the
// result register together, so a result is presented from the result register
// after its item has passed through the input register.
// One item is taken every cycle while req_stall is low; the state loop is a
// single small update. When the receiver stalls, the result register holds,
// the input register fills and req_stall rises until the result is taken.
// The csr_ port writes prescale_period, debounce_count and key_count; it is
// always ready and should only be used while the block is idle.
// Synchronous reset empties both stages and restores register defaults.
// ----------------------------------------------------------------------------
module key_debounce_release_event #(
   parameter int unsigned MAX_KEYS = 8
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire  [1:0]                req_kind,
   input  kdre_pkg::levels_type      req_key_levels,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output kdre_pkg::key_type         rsp_event_value,
   output kdre_pkg::key_type         rsp_latest_key,
   output kdre_pkg::key_type         rsp_stable_key,
   output logic                      rsp_event_pending,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire  [1:0]                csr_index,
   input  wire  [7:0]                csr_data
);
   import kdre_pkg::*;

   localparam int unsigned KeyLimitInt = (MAX_KEYS < LevelBits) ? MAX_KEYS : LevelBits;
   localparam key_type     KeyLimit    = KeyBits'(KeyLimitInt);

   // Configuration registers.
   count_type prescale_ff, debounce_ff;
   key_type   key_count_ff;

   // Input stage.
   logic       in_valid_ff;
   logic [1:0] in_kind_ff;
   levels_type in_levels_ff;

   // Debounce state.
   count_type tick_ff, tick_in;
   key_type   last_raw_ff, last_raw_in;
   key_type   stable_ff, stable_in;
   count_type equal_ff, equal_in;
   key_type   pending_ff, pending_in;
   key_type   latest_ff, latest_in;

   // Result stage.
   logic       out_valid_ff;
   result_type result_ff, result_in;

   logic      advance;
   key_type   enabled_keys;
   key_type   raw_key;
   count_type tick_next;
   key_type   event_key;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff  <= ResetPrescale;
         debounce_ff  <= ResetDebounce;
         key_count_ff <= ResetKeyCount;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PRESCALE:  prescale_ff  <= csr_data;
            CSR_DEBOUNCE:  debounce_ff  <= csr_data;
            CSR_KEY_COUNT: key_count_ff <= csr_data[KeyBits-1:0];
            default:       ;
         endcase
      end
   end

   // The input register moves on whenever the result register is free or drains.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_kind_ff   <= req_kind;
         in_levels_ff <= req_key_levels;
      end
   end

   assign enabled_keys = (key_count_ff < KeyLimit) ? key_count_ff : KeyLimit;

   kdre_encode u_encode (
      .levels       (in_levels_ff),
      .enabled_keys (enabled_keys),
      .key_number   (raw_key)
   );

   assign tick_next = tick_ff + 8'd1;

   always_comb begin
      tick_in     = tick_ff;
      last_raw_in = last_raw_ff;
      stable_in   = stable_ff;
      equal_in    = equal_ff;
      pending_in  = pending_ff;
      latest_in   = latest_ff;
      event_key   = '0;
      unique case (in_kind_ff)
         KIND_TICK: begin
            if (tick_next < prescale_ff) begin
               tick_in = tick_next;
            end else begin
               tick_in = '0;
               if (raw_key == last_raw_ff) begin
                  if (equal_ff < debounce_ff) begin
                     equal_in = equal_ff + 8'd1;
                  end
               end else begin
                  last_raw_in = raw_key;
                  equal_in    = 8'd1;
               end
               if ((equal_in >= debounce_ff) && (last_raw_in != stable_ff)) begin
                  stable_in = last_raw_in;
                  // A change from a pressed key to none is a release.
                  if ((last_raw_in == '0) && (stable_ff != '0)) begin
                     pending_in = stable_ff;
                  end
               end
            end
         end
         KIND_READ: begin
            event_key  = pending_ff;
            pending_in = '0;
            if (pending_ff != '0) begin
               latest_in = pending_ff;
            end
         end
         KIND_INIT: begin
            pending_in  = '0;
            latest_in   = '0;
            last_raw_in = raw_key;
            stable_in   = raw_key;
            equal_in    = debounce_ff;
            tick_in     = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         last_raw_ff <= '0;
         stable_ff   <= '0;
         equal_ff    <= ResetDebounce;
         pending_ff  <= '0;
         latest_ff   <= '0;
      end else if (advance) begin
         tick_ff     <= tick_in;
         last_raw_ff <= last_raw_in;
         stable_ff   <= stable_in;
         equal_ff    <= equal_in;
         pending_ff  <= pending_in;
         latest_ff   <= latest_in;
      end
   end

   always_comb begin
      result_in.event_value   = event_key;
      result_in.latest_key    = latest_in;
      result_in.stable_key    = stable_in;
      result_in.event_pending = (pending_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_value   = result_ff.event_value;
   assign rsp_latest_key    = result_ff.latest_key;
   assign rsp_stable_key    = result_ff.stable_key;
   assign rsp_event_pending = result_ff.event_pending;

endmodule : key_debounce_release_event
`default_nettype wire

// ----- sv/kdre_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key debouncer port checker
// Watches the ports of the debouncer for handshake and result consistency.
// ----------------------------------------------------------------------------
module kdre_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_stall,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input kdre_pkg::key_type      rsp_event_value,
   input kdre_pkg::key_type      rsp_latest_key,
   input kdre_pkg::key_type      rsp_stable_key,
   input wire                    rsp_event_pending
);
   import kdre_pkg::*;

   // A stalled result keeps its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_value)
         && $stable(rsp_latest_key) && $stable(rsp_stable_key)
         && $stable(rsp_event_pending))
      else $error("stalled result changed");

   // A read that hands out an event records it as the latest key and clears it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_value != '0) |->
         (rsp_latest_key == rsp_event_value) && !rsp_event_pending)
      else $error("read event not reflected in status");

   // Reset leaves no result behind.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result present after reset");

   // Every accepted item is followed by rsp_valid high after the input and result registers.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("accepted item produced no result");

endmodule : kdre_checker

bind key_debounce_release_event kdre_checker u_kdre_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_event_value   (rsp_event_value),
   .rsp_latest_key    (rsp_latest_key),
   .rsp_stable_key    (rsp_stable_key),
   .rsp_event_pending (rsp_event_pending)
);
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the multi-key debouncer with release events
// A queue-fed driver sends tick, read, init and unused-kind items under a
// series of register settings. A local predictor of the debounce state
// supplies the expected result for every transfer, and a monitor compares
// all fields of each result. Both sides idle at random outside steady phases.
// ----------------------------------------------------------------------------
module tb;
   import kdre_pkg::*;

   localparam int unsigned MaxKeys    = 8;
   localparam logic [1:0]  KindUnused = 2'd3;
   localparam int          IdleChance = 30;
   localparam int          DrainGuard = 20000;
   localparam int          ReportMax  = 10;

   typedef struct {
      logic [1:0] kind;
      levels_type levels;
   } key_item_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [1:0] req_kind       = KIND_TICK;
   levels_type req_key_levels = '1;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   key_type    rsp_event_value;
   key_type    rsp_latest_key;
   key_type    rsp_stable_key;
   logic       rsp_event_pending;
   logic       csr_valid      = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index      = CSR_PRESCALE;
   logic [7:0] csr_data       = '0;

   // Register copies used by the predictor
   count_type cfg_prescale;
   count_type cfg_debounce;
   key_type   cfg_key_count;

   // Predicted debouncer state
   count_type sample_divider;
   key_type   raw_key_seen;
   key_type   debounced_key;
   key_type   prior_debounced_key;
   count_type repeat_count;
   key_type   release_pending_key;
   key_type   last_read_key;

   key_item_type pending_items[$];
   result_type   expected_results[$];
   result_type   predicted_result;
   result_type   observed_result;
   result_type   wanted_result;

   bit steady = 1'b0;
   int fail_count = 0;
   int report_count = 0;
   int items_taken = 0;
   int results_checked = 0;
   int releases_read = 0;
   int settings_count = 0;

   key_debounce_release_event #(
      .MAX_KEYS(MaxKeys)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_key_levels   (req_key_levels),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_value  (rsp_event_value),
      .rsp_latest_key   (rsp_latest_key),
      .rsp_stable_key   (rsp_stable_key),
      .rsp_event_pending(rsp_event_pending),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #4 clock = ~clock;

   // Lowest enabled pressed key, numbered from one; zero when none is pressed.
   function automatic key_type priority_key(levels_type levels);
      int unsigned enabled;
      int unsigned i;
      key_type     found;
      found = '0;
      enabled = cfg_key_count;
      if (enabled > MaxKeys) enabled = MaxKeys;
      if (enabled > LevelBits) enabled = LevelBits;
      // Scanning downwards lets the lowest pressed key win.
      for (i = enabled; i > 0; i--) begin
         if (!levels[i-1]) found = key_type'(i);
      end
      return found;
   endfunction

   task automatic debounce_step(input logic [1:0] kind, input levels_type levels,
                                output result_type res);
      count_type next_div;
      key_type   raw;
      key_type   handed;
      handed = '0;
      case (kind)
         KIND_TICK: begin
            next_div = sample_divider + 8'd1;
            if (next_div < cfg_prescale) begin
               sample_divider = next_div;
            end else begin
               sample_divider = '0;
               raw = priority_key(levels);
               if (raw == raw_key_seen) begin
                  if (repeat_count < cfg_debounce) repeat_count = repeat_count + 8'd1;
               end else begin
                  raw_key_seen = raw;
                  repeat_count = 8'd1;
               end
               if (repeat_count >= cfg_debounce && raw_key_seen != debounced_key) begin
                  prior_debounced_key = debounced_key;
                  debounced_key = raw_key_seen;
                  // Only a change from a pressed key to none counts as a release.
                  if (debounced_key == '0 && prior_debounced_key != '0) begin
                     release_pending_key = prior_debounced_key;
                  end
               end
            end
         end
         KIND_READ: begin
            handed = release_pending_key;
            release_pending_key = '0;
            if (handed != '0) last_read_key = handed;
         end
         KIND_INIT: begin
            release_pending_key = '0;
            last_read_key = '0;
            raw_key_seen = priority_key(levels);
            debounced_key = raw_key_seen;
            prior_debounced_key = raw_key_seen;
            repeat_count = cfg_debounce;
            sample_divider = '0;
         end
         default: begin
         end
      endcase
      res.event_value = handed;
      res.latest_key = last_read_key;
      res.stable_key = debounced_key;
      res.event_pending = (release_pending_key != '0);
   endtask

   // Driver: presents queued items and predicts each one as it is transferred.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            debounce_step(req_kind, req_key_levels, predicted_result);
            expected_results.push_back(predicted_result);
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() > 0 &&
                (steady || $urandom_range(0, 99) >= IdleChance)) begin
               req_valid      <= 1'b1;
               req_kind       <= pending_items[0].kind;
               req_key_levels <= pending_items[0].levels;
               void'(pending_items.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every result transfer against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            observed_result.event_value = rsp_event_value;
            observed_result.latest_key = rsp_latest_key;
            observed_result.stable_key = rsp_stable_key;
            observed_result.event_pending = rsp_event_pending;
            if (observed_result.event_value != '0) releases_read++;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (report_count < ReportMax) begin
                  report_count++;
                  $display("Unexpected result at %0t ns: event %0d latest %0d stable %0d",
                           $time, rsp_event_value, rsp_latest_key, rsp_stable_key);
               end
            end else begin
               wanted_result = expected_results.pop_front();
               results_checked++;
               if (observed_result !== wanted_result) begin
                  fail_count++;
                  if (report_count < ReportMax) begin
                     report_count++;
                     $display({"Mismatch at %0t ns: expected event %0d latest %0d ",
                               "stable %0d pending %0b, got %0d %0d %0d %0b"},
                              $time, wanted_result.event_value, wanted_result.latest_key,
                              wanted_result.stable_key, wanted_result.event_pending,
                              observed_result.event_value, observed_result.latest_key,
                              observed_result.stable_key, observed_result.event_pending);
                  end
               end
            end
         end
         rsp_stall <= !steady && ($urandom_range(0, 99) < IdleChance);
      end
   end

   task automatic write_register(input csr_index_type idx, input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PRESCALE:  cfg_prescale = value;
         CSR_DEBOUNCE:  cfg_debounce = value;
         CSR_KEY_COUNT: cfg_key_count = value[3:0];
         default: begin
         end
      endcase
   endtask

   task automatic apply_setting(input count_type prescale, input count_type debounce,
                                input logic [7:0] keys);
      write_register(CSR_PRESCALE, prescale);
      write_register(CSR_DEBOUNCE, debounce);
      write_register(CSR_KEY_COUNT, keys);
      settings_count++;
      @(negedge clock);
   endtask

   task automatic queue_item(input logic [1:0] kind, input levels_type levels);
      key_item_type item;
      item.kind = kind;
      item.levels = levels;
      pending_items.push_back(item);
   endtask

   // Mostly held key patterns, often long enough to get through the debounce count,
   // with reads, the odd init, noise samples and unused kinds mixed in.
   task automatic queue_random_items(input int count);
      levels_type held;
      int         run_left;
      int         pick;
      int         span;
      int         n;
      held = '1;
      run_left = 0;
      span = (int'(cfg_prescale) + 1) * (int'(cfg_debounce) + 1);
      if (span > 40) span = 40;
      for (n = 0; n < count; n++) begin
         if (run_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) held = '1;
            else if (pick < 8) held = ~(levels_type'(1) << $urandom_range(0, 7));
            else held = levels_type'($urandom);
            run_left = $urandom_range(1, 2 * span);
         end
         run_left--;
         pick = $urandom_range(0, 99);
         if (pick < 76) begin
            if ($urandom_range(0, 19) == 0) queue_item(KIND_TICK, levels_type'($urandom));
            else queue_item(KIND_TICK, held);
         end else if (pick < 92) begin
            queue_item(KIND_READ, levels_type'($urandom));
         end else if (pick < 97) begin
            queue_item(KIND_INIT, held);
         end else begin
            queue_item(KindUnused, levels_type'($urandom));
         end
      end
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      while ((pending_items.size() != 0 || req_valid || expected_results.size() != 0)
             && guard < DrainGuard) begin
         @(negedge clock);
         guard++;
      end
      if (guard >= DrainGuard) begin
         fail_count++;
         $display("Traffic did not drain: %0d items queued, %0d results outstanding",
                  pending_items.size(), expected_results.size());
      end
   endtask

   task automatic run_phase(input count_type prescale, input count_type debounce,
                            input logic [7:0] keys, input int count);
      apply_setting(prescale, debounce, keys);
      queue_random_items(count);
      wait_drained();
   endtask

   initial begin
      cfg_prescale = ResetPrescale;
      cfg_debounce = ResetDebounce;
      cfg_key_count = ResetKeyCount;
      sample_divider = '0;
      raw_key_seen = '0;
      debounced_key = '0;
      prior_debounced_key = '0;
      repeat_count = ResetDebounce;
      release_pending_key = '0;
      last_read_key = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // A few items at the reset settings leave the sample divider part-way.
      @(negedge clock);
      queue_random_items(12);
      wait_drained();

      // With the new period of one every tick samples; the init first clears the divider.
      apply_setting(8'd1, 8'd1, 8'd8);
      queue_item(KIND_INIT, 8'hFF);
      queue_item(KIND_TICK, 8'hFE);
      queue_item(KIND_TICK, 8'hFF);
      queue_item(KIND_READ, 8'h00);
      queue_item(KIND_READ, 8'hFF);
      queue_item(KIND_TICK, 8'h7F);
      queue_item(KIND_TICK, 8'hFF);
      // A second release before any read replaces the pending event.
      queue_item(KIND_TICK, 8'hFB);
      queue_item(KIND_TICK, 8'hFF);
      queue_item(KIND_READ, 8'h55);
      queue_item(KIND_TICK, 8'h00);
      queue_item(KindUnused, 8'h00);
      queue_item(KIND_INIT, 8'h00);
      queue_item(KIND_TICK, 8'hFF);
      queue_item(KindUnused, 8'hFF);
      queue_item(KIND_READ, 8'hAA);
      queue_item(KIND_TICK, 8'h80);
      queue_item(KIND_TICK, 8'h7F);
      queue_item(KIND_TICK, 8'hFF);
      queue_item(KIND_INIT, 8'hFF);
      queue_item(KIND_READ, 8'hFF);
      wait_drained();

      // Zero period and zero count: every tick samples and settles at once.
      apply_setting(8'd0, 8'd0, 8'd3);
      queue_item(KIND_TICK, 8'hF7);
      queue_item(KIND_TICK, 8'hFD);
      queue_item(KIND_TICK, 8'hFF);
      queue_item(KIND_READ, 8'h00);
      wait_drained();

      run_phase(8'd20, 8'd3, 8'd8, 60);
      steady = 1'b1;
      run_phase(8'd1, 8'd1, 8'd8, 120);
      steady = 1'b0;
      run_phase(8'd0, 8'd0, 8'd8, 80);
      run_phase(8'd2, 8'd3, 8'd8, 80);
      run_phase(8'd3, 8'd2, 8'd5, 80);
      run_phase(8'd1, 8'd2, 8'd15, 80);
      run_phase(8'd0, 8'd1, 8'd1, 60);
      run_phase(8'd255, 8'd255, 8'd8, 40);
      run_phase(8'd1, 8'd1, 8'd8, 80);
      run_phase(8'd0, 8'd4, 8'd12, 70);
      run_phase(8'd2, 8'd1, 8'd0, 40);
      run_phase(8'd1, 8'd255, 8'd8, 30);
      run_phase(8'd4, 8'd2, 8'd8, 60);
      // Only the low four data bits reach the key count.
      run_phase(8'd1, 8'd1, 8'hF5, 50);

      repeat (10) @(posedge clock);
      fail_count += expected_results.size();

      $display("Checked %0d results for %0d items over %0d register settings.",
               results_checked, items_taken, settings_count);
      $display("Release events handed out by reads: %0d.", releases_read);
      if (fail_count == 0) begin
         $display("[key_debounce_release_event] OK");
      end else begin
         $display("[key_debounce_release_event] ERROR");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Run stopped at the time limit.");
      $display("[key_debounce_release_event] ERROR");
      $finish;
   end

endmodule
